// ----- rtl/stream_dma_channel_top_defines.svh -----
// Assertion macros used by the stream DMA channel engine
`ifndef STREAM_DMA_CHANNEL_TOP_DEFINES_SVH
`define STREAM_DMA_CHANNEL_TOP_DEFINES_SVH
// Assert that a condition implies a consequence in the same cycle
`define SDC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Assert that a condition implies a consequence in the next cycle
`define SDC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ----- rtl/sdc_pkg.sv -----
// Package: types and constants for the stream DMA channel
package sdc_pkg;
    localparam int ADDR_HIGH_BITS  = 17;
    localparam int DONE_COUNT_BITS = 3;
    localparam int QUEUE_DEPTH     = 4;
    localparam int QUEUE_PTR_BITS  = 2;

    localparam logic [2:0] FUNC_REG_WRITE = 3'd0;
    localparam logic [2:0] FUNC_REG_READ  = 3'd1;
    localparam logic [2:0] FUNC_STREAM_IN = 3'd2;
    localparam logic [2:0] FUNC_MEM_DATA  = 3'd3;
    localparam logic [2:0] FUNC_TICK      = 3'd4;

    localparam logic [2:0] KIND_ACK       = 3'd0;
    localparam logic [2:0] KIND_READ_DATA = 3'd1;
    localparam logic [2:0] KIND_MEM_WRITE = 3'd2;
    localparam logic [2:0] KIND_STREAM    = 3'd3;
    localparam logic [2:0] KIND_READ_REQ  = 3'd4;

    localparam logic [3:0] REG_ADDR_LOW  = 4'd0;
    localparam logic [3:0] REG_SIZE      = 4'd1;
    localparam logic [3:0] REG_STATUS    = 4'd2;
    localparam logic [3:0] REG_CTRL      = 4'd3;
    localparam logic [3:0] REG_SUM       = 4'd4;
    localparam logic [3:0] REG_INT_STAT  = 4'd5;
    localparam logic [3:0] REG_INT_EN    = 4'd6;
    localparam logic [3:0] REG_INT_DIS   = 4'd7;
    localparam logic [3:0] REG_INT_MASK  = 4'd8;
    localparam logic [3:0] REG_CTRL2     = 4'd9;
    localparam logic [3:0] REG_ADDR_HIGH = 4'd10;

    localparam logic CFG_CHANNEL_IS_DST = 1'b0;
    localparam logic CFG_BYTE_ALIGN     = 1'b1;

    localparam logic [24:0] CTRL_RESET_SRC  = 25'h3FFE00;
    localparam logic [24:0] CTRL_RESET_DST  = 25'h3FFF00;
    localparam logic [27:0] CTRL2_RESET     = 28'h81BFFF8;
    localparam logic [7:0]  MASK_RESET_SRC  = 8'h7F;
    localparam logic [7:0]  MASK_RESET_DST  = 8'hFE;

    // One accepted request as passed from front to back
    typedef struct packed {
        logic [2:0]  func;
        logic [3:0]  reg_index;
        logic [31:0] write_data;
        logic [31:0] word_data;
        logic [2:0]  word_bytes;
        logic        downstream_ready;
    } t_req;

    // One result item
    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] read_data;
        logic [48:0] mem_addr;
        logic [31:0] out_data;
        logic [2:0]  out_bytes;
        logic        stream_end;
        logic        irq;
        logic        dropped;
        logic        last;
    } t_res;

    function automatic logic [31:0] keep_bytes(input logic [31:0] x, input logic [2:0] n);
        logic [31:0] m;
        case (n)
            3'd0:    m = 32'h0;
            3'd1:    m = 32'h0000_00FF;
            3'd2:    m = 32'h0000_FFFF;
            3'd3:    m = 32'h00FF_FFFF;
            default: m = 32'hFFFF_FFFF;
        endcase
        return x & m;
    endfunction

    function automatic logic [31:0] swap_bytes(input logic [31:0] x);
        return {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction
endpackage

// ----- rtl/sdc_front.sv -----
// Front end: accept requests and queue them for the execution engine
module sdc_front
    import sdc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_req i_req,
    output logic o_q_valid,
    input  logic i_q_pop,
    output t_req o_q_req
);
    t_req                    r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] r_wr, r_rd;
    logic [QUEUE_PTR_BITS:0]   r_cnt;
    logic                    push, pop;

    assign o_ready   = (r_cnt != (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
    assign push      = i_valid && o_ready;
    assign o_q_valid = (r_cnt != '0);
    assign pop       = i_q_pop && o_q_valid;
    assign o_q_req   = r_mem[r_rd];

    // Store incoming requests
    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wr] <= i_req;
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wr <= r_wr + 1'b1;
            if (pop)  r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + (QUEUE_PTR_BITS+1)'(push) - (QUEUE_PTR_BITS+1)'(pop);
        end
    end
endmodule

// ----- rtl/sdc_engine.sv -----
// Execution engine: register bank, transfer state and result generation
module sdc_engine
    import sdc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_index,
    input  logic        i_cfg_data,
    input  logic        i_q_valid,
    output logic        o_q_pop,
    input  t_req        i_q_req,
    output logic        o_res_valid,
    input  logic        i_res_take,
    output t_res        o_res
);
    `include "stream_dma_channel_top_defines.svh"

    logic                      r_is_dst, r_balign;
    logic [31:0]               r_addr_lo;
    logic [ADDR_HIGH_BITS-1:0] r_addr_hi;
    logic [29:0]               r_size;
    logic                      r_busy;
    logic [DONE_COUNT_BITS-1:0] r_done;
    logic [24:0]               r_ctrl;
    logic [27:0]               r_ctrl2;
    logic [31:0]               r_sum;
    logic [7:0]                r_ist, r_imask;
    logic [11:0]               r_pre, r_tmo;
    logic                      r_trun, r_rpend;

    // Output stage: up to two results held
    t_res r_out0, r_out1;
    logic r_v0, r_v1;

    logic [31:0]               n_addr_lo;
    logic [29:0]               n_size;
    logic                      n_busy;
    logic [DONE_COUNT_BITS-1:0] n_done;
    logic [24:0]               n_ctrl;
    logic [27:0]               n_ctrl2;
    logic [31:0]               n_sum;
    logic [7:0]                n_ist, n_imask;
    logic [11:0]               n_pre, n_tmo;
    logic                      n_trun, n_rpend;
    logic [ADDR_HIGH_BITS-1:0] n_addr_hi;
    t_res                      res0, res1;
    logic                      two;
    logic                      fire;

    // Output side is free when empty, or emptied this cycle with only one held
    assign fire    = i_q_valid && (!r_v0 || (i_res_take && !r_v1));
    assign o_q_pop = fire;
    assign o_res_valid = r_v0;
    assign o_res   = r_out0;

    always_comb begin
        logic [29:0] sz, s, lfm, btt, len, chunk, nadv;
        logic [31:0] x, y, rd;
        logic        paused, adv, rdy, tmo_on, kck, fin;
        logic [2:0]  wb;
        n_addr_lo = r_addr_lo; n_addr_hi = r_addr_hi; n_size = r_size; n_busy = r_busy;
        n_done = r_done; n_ctrl = r_ctrl; n_ctrl2 = r_ctrl2; n_sum = r_sum;
        n_ist = r_ist; n_imask = r_imask; n_pre = r_pre; n_tmo = r_tmo;
        n_trun = r_trun; n_rpend = r_rpend;
        res0 = '0; res1 = '0; two = 1'b0;
        adv = 1'b0; nadv = '0; kck = 1'b0; fin = 1'b0;
        rd = '0; x = '0; y = '0; btt = '0; len = '0; chunk = '0; s = '0;
        rdy = i_q_req.downstream_ready;
        lfm = r_balign ? 30'h2000_0000 : 30'h1;
        sz = {1'b0, (r_balign ? r_size[28:0] : {r_size[28:2], 2'b00})};
        paused = (r_ctrl[1:0] != 2'b00);
        tmo_on = r_ctrl2[22];
        res0.kind = KIND_ACK;
        wb = i_q_req.word_bytes;
        unique case (i_q_req.func)
            FUNC_REG_WRITE: begin
                unique case (i_q_req.reg_index)
                    REG_ADDR_LOW: n_addr_lo = i_q_req.write_data;
                    REG_SIZE: begin
                        n_size = i_q_req.write_data[29:0];
                        n_busy = 1'b1;
                        s = {1'b0, (r_balign ? i_q_req.write_data[28:0]
                                             : {i_q_req.write_data[28:2], 2'b00})};
                        if (s == '0) fin = 1'b1;
                        else if (!r_is_dst) kck = 1'b1;
                        sz = s;
                    end
                    REG_STATUS: n_done = r_done &
                        ~i_q_req.write_data[13 +: DONE_COUNT_BITS];
                    REG_CTRL: begin
                        n_ctrl = i_q_req.write_data[24:0];
                        if (!r_is_dst && i_q_req.write_data[1:0] == 2'b00) kck = 1'b1;
                    end
                    REG_SUM: n_sum = i_q_req.write_data;
                    REG_INT_STAT: begin
                        if (i_q_req.write_data[1] && r_ist[1]) n_done = r_done - 1'b1;
                        n_ist = r_ist & ~i_q_req.write_data[7:0];
                    end
                    REG_INT_EN:  n_imask = r_imask & ~i_q_req.write_data[7:0];
                    REG_INT_DIS: n_imask = r_imask | i_q_req.write_data[7:0];
                    REG_CTRL2:   n_ctrl2 = i_q_req.write_data[27:0];
                    REG_ADDR_HIGH: n_addr_hi = i_q_req.write_data[ADDR_HIGH_BITS-1:0];
                    default: ;
                endcase
            end
            FUNC_REG_READ: begin
                unique case (i_q_req.reg_index)
                    REG_ADDR_LOW: rd = r_addr_lo;
                    REG_SIZE:     rd = {2'b00, r_size};
                    REG_STATUS:   rd = 32'({r_done, 12'h0, r_busy});
                    REG_CTRL:     rd = {7'h0, r_ctrl};
                    REG_SUM:      rd = r_sum;
                    REG_INT_STAT: rd = {24'h0, r_ist};
                    REG_INT_MASK: rd = {24'h0, r_imask};
                    REG_CTRL2:    rd = {4'h0, r_ctrl2};
                    REG_ADDR_HIGH: rd = 32'(r_addr_hi);
                    default:      rd = '0;
                endcase
                res0.kind = KIND_READ_DATA;
                res0.read_data = rd;
            end
            FUNC_STREAM_IN: begin
                if (r_is_dst) begin
                    len = r_balign ? ((wb > 3'd4) ? 30'd4 : 30'(wb)) : 30'd4;
                    if (len != '0) begin
                        btt = (sz < len) ? sz : len;
                        if (paused || btt == '0) begin
                            n_ist = n_ist | 8'h80;
                            res0.dropped = 1'b1;
                        end else begin
                            x = keep_bytes(i_q_req.word_data, len[2:0]);
                            y = keep_bytes(r_ctrl[23] ? swap_bytes(x) : x, btt[2:0]);
                            res0.kind = KIND_MEM_WRITE;
                            res0.mem_addr = {r_addr_hi, r_addr_lo};
                            res0.out_data = y;
                            res0.out_bytes = btt[2:0];
                            adv = 1'b1; nadv = btt;
                        end
                    end
                end
            end
            FUNC_MEM_DATA: begin
                if (!r_is_dst && r_rpend) begin
                    chunk = (sz < 30'd4) ? sz : 30'd4;
                    n_rpend = 1'b0;
                    if (chunk != '0) begin
                        x = keep_bytes(i_q_req.word_data, chunk[2:0]);
                        n_sum = r_sum + x;
                        y = keep_bytes(r_ctrl[23] ? swap_bytes(x) : x, chunk[2:0]);
                        res0.kind = KIND_STREAM;
                        res0.out_data = y;
                        res0.out_bytes = chunk[2:0];
                        res0.stream_end = (chunk == sz) && ((r_size & lfm) != '0);
                        adv = 1'b1; nadv = chunk;
                        kck = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        // Advance the transfer
        if (adv) begin
            s = sz - nadv;
            if (!r_ctrl[22]) n_addr_lo = r_addr_lo + 32'(nadv);
            n_size = (r_size & lfm) | {1'b0, s[28:0]};
            if (s == '0) fin = 1'b1;
            sz = s;
        end
        // Complete the transfer
        if (fin) begin
            n_done = n_done + 1'b1;
            n_busy = 1'b0;
            n_ist  = n_ist | (r_is_dst ? 8'h02 : 8'h03);
        end
        // Restart the stall timer
        if (kck) begin
            n_trun = 1'b0;
            if (r_ctrl2[22] && sz != '0 && !rdy) begin
                n_pre  = r_ctrl2[15:4];
                n_tmo  = (i_q_req.func == FUNC_REG_WRITE && i_q_req.reg_index == REG_CTRL)
                         ? i_q_req.write_data[21:10] : r_ctrl[21:10];
                n_trun = 1'b1;
            end
        end
        if (!r_is_dst && rdy) n_trun = 1'b0;
        // Count the stall timer
        if (i_q_req.func == FUNC_TICK && n_trun) begin
            if (n_pre != '0) n_pre = n_pre - 1'b1;
            else begin
                n_pre = r_ctrl2[15:4];
                if (n_tmo <= 12'd1) begin
                    n_trun = 1'b0;
                    if (tmo_on) n_ist = n_ist | 8'h08;
                end else n_tmo = n_tmo - 1'b1;
            end
        end
        // Issue a memory read request
        if (!r_is_dst && sz != '0 && n_ctrl[1:0] == 2'b00 && rdy && !n_rpend) begin
            n_rpend = 1'b1;
            two = 1'b1;
            res1.kind = KIND_READ_REQ;
            res1.mem_addr = {n_addr_hi, n_addr_lo};
            res1.out_bytes = (sz < 30'd4) ? sz[2:0] : 3'd4;
        end
        res0.irq = (n_ist & ~n_imask) != 8'h0;
        res1.irq = res0.irq;
        res0.last = !two;
        res1.last = 1'b1;
    end

    // Update channel state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_is_dst <= 1'b1; r_balign <= 1'b0;
            r_addr_lo <= '0; r_addr_hi <= '0; r_size <= '0; r_busy <= 1'b0;
            r_done <= '0; r_ctrl <= CTRL_RESET_DST; r_ctrl2 <= CTRL2_RESET;
            r_sum <= '0; r_ist <= '0; r_imask <= MASK_RESET_DST;
            r_pre <= '0; r_tmo <= '0; r_trun <= 1'b0; r_rpend <= 1'b0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_CHANNEL_IS_DST) begin
                r_is_dst <= i_cfg_data;
                r_ctrl   <= i_cfg_data ? CTRL_RESET_DST : CTRL_RESET_SRC;
                r_imask  <= i_cfg_data ? MASK_RESET_DST : MASK_RESET_SRC;
            end else r_balign <= i_cfg_data;
        end else if (fire) begin
            r_addr_lo <= n_addr_lo; r_addr_hi <= n_addr_hi; r_size <= n_size;
            r_busy <= n_busy; r_done <= n_done; r_ctrl <= n_ctrl; r_ctrl2 <= n_ctrl2;
            r_sum <= n_sum; r_ist <= n_ist; r_imask <= n_imask;
            r_pre <= n_pre; r_tmo <= n_tmo; r_trun <= n_trun; r_rpend <= n_rpend;
        end
    end

    // Hold results until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0; r_v1 <= 1'b0;
        end else if (fire) begin
            r_v0 <= 1'b1; r_v1 <= two;
        end else if (i_res_take && r_v0) begin
            r_v0 <= r_v1; r_v1 <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out0 <= res0; r_out1 <= res1;
        end else if (i_res_take && r_v0) begin
            r_out0 <= r_out1;
        end
    end

    `SDC_ASSERT_IMP(a_pair_order, i_clk, i_rst_n, r_v1, r_v0)
    `SDC_ASSERT_IMP(a_second_last, i_clk, i_rst_n, r_v1, r_out1.last && !r_out0.last)
    `SDC_ASSERT_NEXT(a_req_pend, i_clk, i_rst_n, fire && two, r_rpend)
endmodule

// ----- rtl/stream_dma_channel_top.sv -----
// Throughput: one request per cycle when each yields one result, if results are
// taken at once and no config write stalls; a two-result request holds the next
// until its second result leaves the single output port. A request is queued on
// acceptance, popped by the engine, and its first result registered at the pop.
// Reset: synchronous active-low clears the queue, results and register bank to
// destination-role defaults; no clearing pass.
module stream_dma_channel_top
    import sdc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic        i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_func,
    input  logic [3:0]  i_reg_index,
    input  logic [31:0] i_write_data,
    input  logic [31:0] i_word_data,
    input  logic [2:0]  i_word_bytes,
    input  logic        i_downstream_ready,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_kind,
    output logic [31:0] o_read_data,
    output logic [48:0] o_mem_addr,
    output logic [31:0] o_out_data,
    output logic [2:0]  o_out_bytes,
    output logic        o_stream_end,
    output logic        o_irq,
    output logic        o_dropped,
    output logic        o_last
);
    t_req req, q_req;
    t_res res;
    logic q_valid, q_pop;

    assign req = '{func: i_func, reg_index: i_reg_index, write_data: i_write_data,
                   word_data: i_word_data, word_bytes: i_word_bytes,
                   downstream_ready: i_downstream_ready};
    assign o_cfg_ready = 1'b1;

    sdc_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_req(req), .o_q_valid(q_valid), .i_q_pop(q_pop), .o_q_req(q_req)
    );

    sdc_engine u_engine (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_valid(i_cfg_valid),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_q_valid(q_valid && !i_cfg_valid), .o_q_pop(q_pop), .i_q_req(q_req),
        .o_res_valid(o_valid), .i_res_take(i_ready), .o_res(res)
    );

    assign o_kind       = res.kind;
    assign o_read_data  = res.read_data;
    assign o_mem_addr   = res.mem_addr;
    assign o_out_data   = res.out_data;
    assign o_out_bytes  = res.out_bytes;
    assign o_stream_end = res.stream_end;
    assign o_irq        = res.irq;
    assign o_dropped    = res.dropped;
    assign o_last       = res.last;
endmodule

// ----- verif/stream_dma_channel_top_test.sv -----
// Testbench for the stream DMA channel: directed table and random requests checked against a predictor
module stream_dma_channel_top_test;
    import sdc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [2:0]  func;
        logic [3:0]  idx;
        logic [31:0] wdata;
        logic [31:0] word;
        logic [2:0]  wbytes;
        logic        dready;
        logic        has_exp;   // typed-in first result below is checked too
        logic [2:0]  exp_kind;
        logic [31:0] exp_rdata;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = 1'b0;
    logic        i_cfg_data = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [2:0]  i_func = '0;
    logic [3:0]  i_reg_index = '0;
    logic [31:0] i_write_data = '0;
    logic [31:0] i_word_data = '0;
    logic [2:0]  i_word_bytes = '0;
    logic        i_downstream_ready = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [2:0]  o_kind;
    logic [31:0] o_read_data;
    logic [48:0] o_mem_addr;
    logic [31:0] o_out_data;
    logic [2:0]  o_out_bytes;
    logic        o_stream_end;
    logic        o_irq;
    logic        o_dropped;
    logic        o_last;

    stream_dma_channel_top dut (.*);

    always #5 i_clk = ~i_clk;

    // Channel shadow state
    logic        m_is_dst, m_align;
    logic [31:0] m_addr_lo, m_sum;
    logic [16:0] m_addr_hi;
    logic [29:0] m_size;
    logic        m_busy, m_tmr_run, m_rd_pend;
    logic [2:0]  m_done;
    logic [24:0] m_ctrl;
    logic [27:0] m_ctrl2;
    logic [7:0]  m_int, m_mask;
    logic [11:0] m_presc, m_tout;

    t_res        expected_q[$];
    int          errors = 0;
    int          results_seen = 0;
    int          requests_sent = 0;
    int          send_idle = 0;
    int          recv_stall = 0;
    logic        unsettled = 1'b0;   // request sent, results may still be due

    function automatic logic [31:0] cur_size();
        return (m_align ? {2'b0, m_size} : {2'b0, m_size[29:2], 2'b00}) & 32'h1FFF_FFFF;
    endfunction

    function automatic logic [29:0] last_mask();
        return m_align ? 30'h2000_0000 : 30'h1;
    endfunction

    function automatic logic [31:0] clip(input logic [31:0] x, input int n);
        if (n >= 4) return x;
        return x & ((32'h1 << (8 * n)) - 1);
    endfunction

    function automatic logic [31:0] swap32(input logic [31:0] x);
        return {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction

    task automatic load_role_defaults();
        m_ctrl = m_is_dst ? CTRL_RESET_DST : CTRL_RESET_SRC;
        m_mask = m_is_dst ? MASK_RESET_DST : MASK_RESET_SRC;
    endtask

    task automatic reset_channel();
        m_is_dst = 1'b1; m_align = 1'b0;
        m_addr_lo = '0; m_addr_hi = '0; m_size = '0; m_busy = 0; m_done = '0;
        m_ctrl2 = CTRL2_RESET; m_sum = '0; m_int = '0;
        m_presc = '0; m_tout = '0; m_tmr_run = 0; m_rd_pend = 0;
        load_role_defaults();
    endtask

    task automatic complete_transfer();
        m_done = m_done + 3'd1;
        m_busy = 0;
        m_int[1] = 1'b1;
        if (!m_is_dst) m_int[0] = 1'b1;
    endtask

    task automatic advance_by(input logic [31:0] n);
        logic [31:0] s;
        s = cur_size() - n;
        if (!m_ctrl[22]) m_addr_lo = m_addr_lo + n;
        m_size = (m_size & last_mask()) | s[28:0];
        if (s == 0) complete_transfer();
    endtask

    task automatic restart_stall_timer(input logic ready);
        m_tmr_run = 0;
        if (m_ctrl2[22] && cur_size() != 0 && !ready) begin
            m_presc = m_ctrl2[15:4];
            m_tout = m_ctrl[21:10];
            m_tmr_run = 1;
        end
    endtask

    function automatic logic [31:0] reg_value(input logic [3:0] idx);
        case (idx)
            REG_ADDR_LOW:  return m_addr_lo;
            REG_SIZE:      return {2'b0, m_size};
            REG_STATUS:    return ({29'b0, m_done} << 13) | m_busy;
            REG_CTRL:      return {7'b0, m_ctrl};
            REG_SUM:       return m_sum;
            REG_INT_STAT:  return {24'b0, m_int};
            REG_INT_MASK:  return {24'b0, m_mask};
            REG_CTRL2:     return {4'b0, m_ctrl2};
            REG_ADDR_HIGH: return {15'b0, m_addr_hi};
            default:       return '0;
        endcase
    endfunction

    task automatic write_reg(input logic [3:0] idx, input logic [31:0] v, input logic ready);
        case (idx)
            REG_ADDR_LOW: m_addr_lo = v;
            REG_SIZE: begin
                m_size = v[29:0];
                m_busy = 1;
                if (cur_size() == 0) complete_transfer();
                else if (!m_is_dst) restart_stall_timer(ready);
            end
            REG_STATUS: m_done = m_done & ~v[15:13];
            REG_CTRL: begin
                m_ctrl = v[24:0];
                if (!m_is_dst && m_ctrl[1:0] == 0) restart_stall_timer(ready);
            end
            REG_SUM: m_sum = v;
            REG_INT_STAT: begin
                if (v[1] && m_int[1]) m_done = m_done - 3'd1;
                m_int = m_int & ~v[7:0];
            end
            REG_INT_EN:    m_mask = m_mask & ~v[7:0];
            REG_INT_DIS:   m_mask = m_mask | v[7:0];
            REG_CTRL2:     m_ctrl2 = v[27:0];
            REG_ADDR_HIGH: m_addr_hi = v[16:0];
            default: ;
        endcase
    endtask

    // Work out the results of one request and queue them
    task automatic predict_request(input logic [2:0] func, input logic [3:0] idx,
                                   input logic [31:0] wd, input logic [31:0] word,
                                   input logic [2:0] wb, input logic ready);
        t_res r0, r1;
        logic two, swap;
        int len, btt, chunk;
        logic [31:0] sz, x;
        r0 = '0; r1 = '0; two = 0;
        swap = m_ctrl[23];
        if (func == FUNC_REG_WRITE) begin
            write_reg(idx, wd, ready);
        end else if (func == FUNC_REG_READ) begin
            r0.kind = KIND_READ_DATA;
            r0.read_data = reg_value(idx);
        end else if (func == FUNC_STREAM_IN && m_is_dst) begin
            len = m_align ? (wb > 4 ? 4 : int'(wb)) : 4;
            if (len != 0) begin
                sz = cur_size();
                btt = (sz < len) ? int'(sz) : len;
                if (m_ctrl[1:0] != 0 || btt == 0) begin
                    m_int[7] = 1'b1;
                    r0.dropped = 1'b1;
                end else begin
                    x = clip(word, len);
                    r0.kind = KIND_MEM_WRITE;
                    r0.mem_addr = {m_addr_hi, m_addr_lo};
                    r0.out_data = clip(swap ? swap32(x) : x, btt);
                    r0.out_bytes = 3'(btt);
                    advance_by(btt);
                end
            end
        end else if (func == FUNC_MEM_DATA && !m_is_dst && m_rd_pend) begin
            sz = cur_size();
            chunk = (sz < 4) ? int'(sz) : 4;
            m_rd_pend = 0;
            if (chunk != 0) begin
                x = clip(word, chunk);
                r0.stream_end = (chunk == sz) && ((m_size & last_mask()) != 0);
                m_sum = m_sum + x;
                r0.kind = KIND_STREAM;
                r0.out_data = clip(swap ? swap32(x) : x, chunk);
                r0.out_bytes = 3'(chunk);
                advance_by(chunk);
                restart_stall_timer(ready);
            end
        end
        if (!m_is_dst && ready) m_tmr_run = 0;
        // Prescaled stall timer
        if (func == FUNC_TICK && m_tmr_run) begin
            if (m_presc != 0) m_presc = m_presc - 1;
            else begin
                m_presc = m_ctrl2[15:4];
                if (m_tout <= 1) begin
                    m_tmr_run = 0;
                    if (m_ctrl2[22]) m_int[3] = 1'b1;
                end else m_tout = m_tout - 1;
            end
        end
        // Issue a memory read request
        if (!m_is_dst && cur_size() != 0 && m_ctrl[1:0] == 0 && ready && !m_rd_pend) begin
            sz = cur_size();
            m_rd_pend = 1;
            r1.kind = KIND_READ_REQ;
            r1.mem_addr = {m_addr_hi, m_addr_lo};
            r1.out_bytes = (sz < 4) ? sz[2:0] : 3'd4;
            two = 1;
        end
        r0.irq = (m_int & ~m_mask) != 0;
        r1.irq = r0.irq;
        r0.last = !two;
        r1.last = 1'b1;
        expected_q.push_back(r0);
        if (two) expected_q.push_back(r1);
    endtask

    // Send one request, holding valid until accepted; drop valid while idling
    task automatic send_request(input logic [2:0] func, input logic [3:0] idx,
                                input logic [31:0] wd, input logic [31:0] word,
                                input logic [2:0] wb, input logic ready);
        while ($urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_func <= func; i_reg_index <= idx; i_write_data <= wd;
        i_word_data <= word; i_word_bytes <= wb; i_downstream_ready <= ready;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_request(func, idx, wd, word, wb, ready);
        requests_sent++;
        unsettled = 1'b1;
    endtask

    // Wait for all results, then let the channel settle
    task automatic drain();
        i_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        unsettled = 1'b0;
    endtask

    task automatic write_config(input logic idx, input logic v);
        i_cfg_valid <= 1'b1; i_cfg_index <= idx; i_cfg_data <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_CHANNEL_IS_DST) begin
            m_is_dst = v;
            load_role_defaults();
        end else m_align = v;
        @(posedge i_clk);
    endtask

    // Stall the result side and check every accepted result
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                results_seen++;
                if (expected_q.size() == 0) begin
                    $error("unexpected result kind %0d", o_kind);
                    errors++;
                end else begin
                    t_res e;
                    e = expected_q.pop_front();
                    if (o_kind !== e.kind) begin
                        $error("kind exp %0d got %0d", e.kind, o_kind); errors++;
                    end
                    if (o_read_data !== e.read_data) begin
                        $error("read_data exp %h got %h", e.read_data, o_read_data); errors++;
                    end
                    if (o_mem_addr !== e.mem_addr) begin
                        $error("mem_addr exp %h got %h", e.mem_addr, o_mem_addr); errors++;
                    end
                    if (o_out_data !== e.out_data) begin
                        $error("out_data exp %h got %h", e.out_data, o_out_data); errors++;
                    end
                    if (o_out_bytes !== e.out_bytes) begin
                        $error("out_bytes exp %0d got %0d", e.out_bytes, o_out_bytes); errors++;
                    end
                    if (o_stream_end !== e.stream_end) begin
                        $error("stream_end exp %b got %b", e.stream_end, o_stream_end); errors++;
                    end
                    if (o_irq !== e.irq) begin
                        $error("irq exp %b got %b", e.irq, o_irq); errors++;
                    end
                    if (o_dropped !== e.dropped) begin
                        $error("dropped exp %b got %b", e.dropped, o_dropped); errors++;
                    end
                    if (o_last !== e.last) begin
                        $error("last exp %b got %b", e.last, o_last); errors++;
                    end
                end
            end
            i_ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    // Random request; mostly well-formed transfers for the current role
    task automatic random_request();
        int pick;
        logic [31:0] v;
        pick = $urandom_range(99);
        v = $urandom;
        if (pick < 8) begin
            // new transfer, small size, random last flag and byte sizes
            v = ($urandom_range(3) == 0) ? $urandom : $urandom_range(40);
            if ($urandom_range(3) == 0) v[29] = 1'b1;
            if ($urandom_range(3) == 0) v[0] = 1'b1;
            send_request(FUNC_REG_WRITE, REG_SIZE, v, '0, 3'd4, $urandom_range(1));
        end else if (pick < 12) begin
            v = $urandom & 32'h00C3_FC03;
            if ($urandom_range(2) != 0) v[1:0] = 2'b00;
            send_request(FUNC_REG_WRITE, REG_CTRL, v, '0, 3'd4, $urandom_range(1));
        end else if (pick < 14) begin
            v = $urandom & 32'h0040_00F0;
            send_request(FUNC_REG_WRITE, REG_CTRL2, v, '0, 3'd4, $urandom_range(1));
        end else if (pick < 22) begin
            send_request(FUNC_REG_WRITE, 4'($urandom_range(15)), $urandom, '0, 3'd4,
                         $urandom_range(1));
        end else if (pick < 34) begin
            send_request(FUNC_REG_READ, 4'($urandom_range(15)), '0, '0, 3'd4,
                         $urandom_range(1));
        end else if (pick < 60) begin
            send_request(FUNC_STREAM_IN, '0, '0, $urandom, 3'($urandom_range(7)),
                         $urandom_range(1));
        end else if (pick < 84) begin
            send_request(FUNC_MEM_DATA, '0, '0, $urandom, 3'd4, $urandom_range(3) != 0);
        end else if (pick < 97) begin
            send_request(FUNC_TICK, '0, '0, '0, 3'd4, $urandom_range(4) == 0);
        end else begin
            send_request(3'($urandom_range(5, 7)), 4'($urandom_range(15)), $urandom,
                         $urandom, 3'($urandom_range(7)), $urandom_range(1));
        end
    endtask

    t_row dir_rows[$];

    task automatic add_row(input logic [2:0] f, input logic [3:0] idx, input logic [31:0] wd,
                           input logic [31:0] w, input logic [2:0] wb, input logic rdy,
                           input logic he, input logic [2:0] ek, input logic [31:0] er);
        t_row r;
        r = '{f, idx, wd, w, wb, rdy, he, ek, er};
        dir_rows.push_back(r);
    endtask

    initial begin
        t_row r;
        int idle_sel[4][2];
        idle_sel = '{'{0, 0}, '{72, 0}, '{0, 72}, '{10, 10}};
        reset_channel();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        i_ready <= 1'b1;
        @(posedge i_clk);

        // Directed: reset values, extremes, drops, zero size, swap, wrap
        add_row(FUNC_REG_READ, REG_CTRL, 0, 0, 4, 0, 1, KIND_READ_DATA, 32'h3FFF00);
        add_row(FUNC_REG_READ, REG_CTRL2, 0, 0, 4, 0, 1, KIND_READ_DATA, 32'h081BFFF8);
        add_row(FUNC_REG_READ, REG_INT_MASK, 0, 0, 4, 0, 1, KIND_READ_DATA, 32'hFE);
        add_row(FUNC_REG_READ, 4'd15, 0, 0, 4, 1, 1, KIND_READ_DATA, 0);
        add_row(FUNC_STREAM_IN, 0, 0, 32'hFFFFFFFF, 4, 1, 0, 0, 0);
        add_row(FUNC_REG_WRITE, REG_ADDR_LOW, 32'hFFFFFFFC, 0, 4, 0, 0, 0, 0);
        add_row(FUNC_REG_WRITE, REG_ADDR_HIGH, 32'hFFFFFFFF, 0, 4, 0, 0, 0, 0);
        add_row(FUNC_REG_WRITE, REG_SIZE, 32'h0000_000D, 0, 4, 0, 0, 0, 0);
        add_row(FUNC_STREAM_IN, 0, 0, 32'h12345678, 4, 0, 0, 0, 0);
        add_row(FUNC_REG_WRITE, REG_CTRL, 32'h00BF_FF00, 0, 4, 0, 0, 0, 0);
        add_row(FUNC_STREAM_IN, 0, 0, 32'hA5A5_0001, 7, 0, 0, 0, 0);
        add_row(FUNC_STREAM_IN, 0, 0, 32'h0, 0, 0, 0, 0, 0);
        add_row(FUNC_REG_WRITE, REG_CTRL, 32'h0000_0001, 0, 4, 0, 0, 0, 0);
        add_row(FUNC_STREAM_IN, 0, 0, 32'h5555_AAAA, 4, 0, 0, 0, 0);
        add_row(FUNC_REG_WRITE, REG_SIZE, 32'h0, 0, 4, 0, 0, 0, 0);
        add_row(FUNC_REG_READ, REG_STATUS, 0, 0, 4, 0, 0, 0, 0);
        add_row(FUNC_REG_WRITE, REG_INT_EN, 32'hFFFFFFFF, 0, 4, 0, 0, 0, 0);
        add_row(FUNC_REG_WRITE, REG_INT_STAT, 32'h2, 0, 4, 0, 0, 0, 0);
        add_row(FUNC_REG_WRITE, REG_STATUS, 32'hFFFFFFFF, 0, 4, 0, 0, 0, 0);
        add_row(FUNC_REG_WRITE, REG_INT_DIS, 32'hFFFFFFFF, 0, 4, 0, 0, 0, 0);
        add_row(FUNC_REG_WRITE, REG_SUM, 32'hFFFFFFFF, 0, 4, 0, 0, 0, 0);
        add_row(FUNC_MEM_DATA, 0, 0, 32'hFFFFFFFF, 4, 1, 0, 0, 0);
        add_row(FUNC_TICK, 0, 0, 0, 4, 0, 0, 0, 0);
        add_row(3'd7, 4'd15, 32'hFFFFFFFF, 32'hFFFFFFFF, 7, 1, 0, 0, 0);

        foreach (dir_rows[i]) begin
            r = dir_rows[i];
            if (r.has_exp) begin
                send_request(r.func, r.idx, r.wdata, r.word, r.wbytes, r.dready);
                // typed-in value must agree with the predictor as well
                if (expected_q[$].kind !== r.exp_kind ||
                    expected_q[$].read_data !== r.exp_rdata) begin
                    $error("read_data exp %h got %h", r.exp_rdata, expected_q[$].read_data);
                    errors++;
                end
            end else send_request(r.func, r.idx, r.wdata, r.word, r.wbytes, r.dready);
        end
        drain();

        // Random phases across roles, alignment and idling patterns
        for (int ph = 0; ph < 8; ph++) begin
            send_idle = idle_sel[ph % 4][0];
            recv_stall = idle_sel[ph % 4][1];
            write_config(CFG_CHANNEL_IS_DST, ph[1] ? 1'b1 : 1'b0);
            write_config(CFG_BYTE_ALIGN, ph[2] ^ ph[0]);
            for (int k = 0; k < 115; k++) random_request();
            drain();
        end

        $display("Ran %0d requests and checked %0d results over both roles,", requests_sent,
                 results_seen);
        $display("both size alignments and four idling patterns.");
        if (errors == 0 && expected_q.size() == 0) $display("stream_dma_channel_top: match");
        else $display("stream_dma_channel_top: mismatch");
        $finish;
    end

    initial begin
        #20ms;
        $display("stream_dma_channel_top: mismatch");
        $finish;
    end
endmodule

// ----- sim.f -----
+incdir+rtl
rtl/sdc_pkg.sv
rtl/sdc_front.sv
rtl/sdc_engine.sv
rtl/stream_dma_channel_top.sv
verif/stream_dma_channel_top_test.sv
